@@ src/windowed_reorder_delivery_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the windowed reorder delivery block
// Shared shorthands for clocked assertions that are disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_REORDER_DELIVERY_TOP_DEFINES_SVH
`define WINDOWED_REORDER_DELIVERY_TOP_DEFINES_SVH

// Plain property, checked at every clock edge out of reset.
`define WRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Implication with an antecedent and a consequent in the same cycle.
`define WRD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

`endif

@@ src/wrd_pkg.sv @@
// ----------------------------------------------------------------------------
// Windowed reorder delivery package
// Types, codes and fixed widths shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package wrd_pkg;

    localparam int ID_W  = 32;
    localparam int PAY_W = 64;
    localparam int CNT_W = 32;
    localparam int CFG_W = 5;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd8;

    localparam logic ACT_OFFER = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        KIND_DELIVER = 2'd0,
        KIND_HELD    = 2'd1,
        KIND_DUP     = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    // Source of a result written to the result buffer.
    typedef enum logic [2:0] {
        PSEL_ITEM,
        PSEL_HELD,
        PSEL_DUP,
        PSEL_NONE,
        PSEL_MATCH,
        PSEL_LOW
    } psel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_CHECK,
        ST_DUP_WAIT,
        ST_INSERT,
        ST_WIN_CHECK,
        ST_WIN_WAIT,
        ST_DRAIN_GO,
        ST_DRAIN_WAIT,
        ST_FLUSH_GO,
        ST_FLUSH_WAIT,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

    typedef struct packed {
        logic  accept;
        logic  start_stream;
        logic  scan_start;
        logic  scan_on_cursor;
        logic  dup_inc;
        logic  push;
        psel_t push_sel;
        logic  cur_inc;
        logic  win_jump;
        logic  insert;
        logic  release_match;
        logic  release_low;
        logic  out_read;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic is_flush;
        logic id_lt_cur;
        logic id_eq_cur;
        logic scan_done;
        logic match_found;
        logic low_found;
        logic over_window;
        logic rb_empty;
        logic out_free;
        logic out_last;
    } stat_t;

endpackage

@@ src/windowed_reorder_delivery_top.sv @@
// ----------------------------------------------------------------------------
// Windowed reorder delivery, top level
// Per-stream reorder buffer with a bounded window of held sequence numbers.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake        | Carries
//  cfg     | in        | cfg_valid/ready  | window size (5 bits)
//  s       | in        | s_valid/ready    | action, stream, message id, payload
//  m       | out       | m_valid/ready    | kind, stream, id, payload, flags, totals
//
// Items are handled one at a time. A search of a stream's held slots reads one
// slot per cycle. An offer passes the start and check states; above the cursor
// it adds one scan for the duplicate check and an insert step, then one scan per
// window skip; every run drains with one scan per id plus one. A flush takes one
// scan per released id plus one. Each result is read from the buffer and then
// loaded into the output register; m_ready stalls hold the output register.
// Reset is synchronous and clears all valid bits at once, so no clearing pass.
// ----------------------------------------------------------------------------
module windowed_reorder_delivery_top #(
    parameter int STREAMS    = 4,
    parameter int WINDOW_MAX = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [wrd_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_action,
    input  logic [1:0]                 s_stream_id,
    input  logic [wrd_pkg::ID_W-1:0]   s_msg_id,
    input  logic [wrd_pkg::PAY_W-1:0]  s_payload,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_kind,
    output logic [1:0]                 m_out_stream,
    output logic [wrd_pkg::ID_W-1:0]   m_out_id,
    output logic [wrd_pkg::PAY_W-1:0]  m_out_payload,
    output logic                       m_gap_before,
    output logic                       m_last,
    output logic [wrd_pkg::CNT_W-1:0]  m_duplicate_total,
    output logic [wrd_pkg::CNT_W-1:0]  m_gap_total
);
    import wrd_pkg::*;

    // The controller decides what happens each cycle; the datapath holds all
    // stream state, the slot memory and the result buffer, and reports back.
    cmd_t  cmd;
    stat_t stat;

    wrd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // Results of one item are gathered in the buffer first, so every transfer
    // carries the running totals as they stand after the whole item.
    wrd_dpath #(
        .STREAMS    (STREAMS),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_action          (s_action),
        .s_stream_id       (s_stream_id),
        .s_msg_id          (s_msg_id),
        .s_payload         (s_payload),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_out_stream      (m_out_stream),
        .m_out_id          (m_out_id),
        .m_out_payload     (m_out_payload),
        .m_gap_before      (m_gap_before),
        .m_last            (m_last),
        .m_duplicate_total (m_duplicate_total),
        .m_gap_total       (m_gap_total),
        .cmd               (cmd),
        .stat              (stat)
    );

endmodule

@@ src/wrd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Windowed reorder delivery controller
// Sequences offer, flush, slot scans and result readout for one item at a time.
// ----------------------------------------------------------------------------
module wrd_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output wrd_pkg::cmd_t  cmd,
    input  wrd_pkg::stat_t stat
);
    import wrd_pkg::*;

    state_t state_reg, state_next;
    logic   drain_win_reg, drain_win_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            drain_win_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            drain_win_reg <= drain_win_next;
        end
    end

    // Next state.
    always_comb begin
        state_next     = state_reg;
        drain_win_next = drain_win_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = stat.is_flush ? ST_FLUSH_GO : ST_CHECK;
            end
            ST_CHECK: begin
                if (stat.id_lt_cur) begin
                    state_next = ST_OUT_RD;
                end else if (stat.id_eq_cur) begin
                    state_next     = ST_DRAIN_GO;
                    drain_win_next = 1'b0;
                end else begin
                    state_next = ST_DUP_WAIT;
                end
            end
            ST_DUP_WAIT: begin
                if (stat.scan_done) begin
                    state_next = stat.match_found ? ST_OUT_RD : ST_INSERT;
                end
            end
            ST_INSERT: begin
                state_next = ST_WIN_CHECK;
            end
            ST_WIN_CHECK: begin
                state_next = stat.over_window ? ST_WIN_WAIT : ST_OUT_RD;
            end
            ST_WIN_WAIT: begin
                if (stat.scan_done) begin
                    if (stat.low_found) begin
                        state_next     = ST_DRAIN_GO;
                        drain_win_next = 1'b1;
                    end else begin
                        state_next = ST_OUT_RD;
                    end
                end
            end
            ST_DRAIN_GO: begin
                state_next = ST_DRAIN_WAIT;
            end
            ST_DRAIN_WAIT: begin
                if (stat.scan_done) begin
                    if (stat.match_found) begin
                        state_next = ST_DRAIN_GO;
                    end else begin
                        state_next = drain_win_reg ? ST_WIN_CHECK : ST_OUT_RD;
                    end
                end
            end
            ST_FLUSH_GO: begin
                state_next = ST_FLUSH_WAIT;
            end
            ST_FLUSH_WAIT: begin
                if (stat.scan_done) begin
                    state_next = stat.low_found ? ST_FLUSH_GO : ST_OUT_RD;
                end
            end
            ST_OUT_RD: begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                if (stat.out_free) begin
                    state_next = stat.out_last ? ST_IDLE : ST_OUT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        cmd          = '0;
        cmd.push_sel = PSEL_NONE;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_START: begin
                cmd.start_stream = !stat.is_flush;
            end
            ST_CHECK: begin
                if (stat.id_lt_cur) begin
                    cmd.dup_inc  = 1'b1;
                    cmd.push     = 1'b1;
                    cmd.push_sel = PSEL_DUP;
                end else if (stat.id_eq_cur) begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = PSEL_ITEM;
                    cmd.cur_inc  = 1'b1;
                end else begin
                    cmd.scan_start = 1'b1;
                end
            end
            ST_DUP_WAIT: begin
                if (stat.scan_done && stat.match_found) begin
                    cmd.dup_inc  = 1'b1;
                    cmd.push     = 1'b1;
                    cmd.push_sel = PSEL_DUP;
                end
            end
            ST_INSERT: begin
                cmd.insert = 1'b1;
            end
            ST_WIN_CHECK: begin
                if (stat.over_window) begin
                    cmd.scan_start = 1'b1;
                end else if (stat.rb_empty) begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = PSEL_HELD;
                end
            end
            ST_WIN_WAIT: begin
                if (stat.scan_done) begin
                    if (stat.low_found) begin
                        cmd.win_jump = 1'b1;
                    end else if (stat.rb_empty) begin
                        cmd.push     = 1'b1;
                        cmd.push_sel = PSEL_HELD;
                    end
                end
            end
            ST_DRAIN_GO: begin
                cmd.scan_start     = 1'b1;
                cmd.scan_on_cursor = 1'b1;
            end
            ST_DRAIN_WAIT: begin
                if (stat.scan_done && stat.match_found) begin
                    cmd.release_match = 1'b1;
                    cmd.push          = 1'b1;
                    cmd.push_sel      = PSEL_MATCH;
                end
            end
            ST_FLUSH_GO: begin
                cmd.scan_start = 1'b1;
            end
            ST_FLUSH_WAIT: begin
                if (stat.scan_done) begin
                    if (stat.low_found) begin
                        cmd.release_low = 1'b1;
                        cmd.push        = 1'b1;
                        cmd.push_sel    = PSEL_LOW;
                    end else if (stat.rb_empty) begin
                        cmd.push     = 1'b1;
                        cmd.push_sel = PSEL_NONE;
                    end
                end
            end
            ST_OUT_RD: begin
                cmd.out_read = 1'b1;
            end
            ST_OUT_LD: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ src/wrd_dpath.sv @@
// ----------------------------------------------------------------------------
// Windowed reorder delivery datapath
// Stream cursors, slot memory with scan unit, result buffer and output stage.
// ----------------------------------------------------------------------------
`include "windowed_reorder_delivery_top_defines.svh"

module wrd_dpath #(
    parameter int STREAMS    = 4,
    parameter int WINDOW_MAX = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [wrd_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       s_action,
    input  logic [1:0]                 s_stream_id,
    input  logic [wrd_pkg::ID_W-1:0]   s_msg_id,
    input  logic [wrd_pkg::PAY_W-1:0]  s_payload,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_kind,
    output logic [1:0]                 m_out_stream,
    output logic [wrd_pkg::ID_W-1:0]   m_out_id,
    output logic [wrd_pkg::PAY_W-1:0]  m_out_payload,
    output logic                       m_gap_before,
    output logic                       m_last,
    output logic [wrd_pkg::CNT_W-1:0]  m_duplicate_total,
    output logic [wrd_pkg::CNT_W-1:0]  m_gap_total,
    input  wrd_pkg::cmd_t              cmd,
    output wrd_pkg::stat_t             stat
);
    import wrd_pkg::*;

    localparam int SLOTS = WINDOW_MAX + 1;
    localparam int ND    = STREAMS * SLOTS;
    localparam int AW    = $clog2(ND);
    localparam int SW    = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int LW    = $clog2(SLOTS);
    localparam int HW    = $clog2(SLOTS + 1);
    localparam int SLW   = ID_W + PAY_W;
    localparam int RBW   = 2 + ID_W + PAY_W + 1;

    // Stream number modulo STREAMS, for a two-bit input.
    function automatic logic [SW-1:0] map_stream(input logic [1:0] v);
        logic [6:0] t;
        t = {5'd0, v};
        for (int i = 0; i < 3; i++) begin
            if (t >= 7'(STREAMS)) begin
                t = t - 7'(STREAMS);
            end
        end
        return SW'(t);
    endfunction

    // Item registers.
    logic             act_reg;
    logic [SW-1:0]    s_reg;
    logic [ID_W-1:0]  id_reg;
    logic [PAY_W-1:0] pay_reg;

    // Stream state.
    logic [STREAMS-1:0] started_reg;
    logic [ID_W-1:0]    cursor_reg [STREAMS];
    logic [HW-1:0]      held_reg [STREAMS];
    logic [ND-1:0]      valid_reg;
    logic [CNT_W-1:0]   dup_reg;
    logic [CNT_W-1:0]   gap_reg;
    logic               gap_flag_reg;
    logic [CFG_W-1:0]   win_reg;

    // Slot memory and scan unit.
    logic [SLW-1:0]   slot_mem [ND];
    logic [SLW-1:0]   slot_rd_reg;
    logic             busy_reg;
    logic [HW-1:0]    cnt_reg;
    logic             pend_reg;
    logic [LW-1:0]    cidx_reg;
    logic [ID_W-1:0]  tgt_reg;
    logic             match_reg;
    logic [LW-1:0]    match_idx_reg;
    logic [PAY_W-1:0] match_pay_reg;
    logic             low_reg;
    logic [LW-1:0]    low_idx_reg;
    logic [ID_W-1:0]  low_id_reg;
    logic [PAY_W-1:0] low_pay_reg;

    // Result buffer.
    logic [RBW-1:0] rb_mem [SLOTS];
    logic [RBW-1:0] rb_rd_reg;
    logic [HW-1:0]  rb_cnt_reg;
    logic [HW-1:0]  rb_rd_idx_reg;

    // Output stage.
    logic             m_valid_reg;
    logic [1:0]       m_kind_reg;
    logic [1:0]       m_stream_reg;
    logic [ID_W-1:0]  m_id_reg;
    logic [PAY_W-1:0] m_pay_reg;
    logic             m_gap_reg;
    logic             m_last_reg;
    logic [CNT_W-1:0] m_dup_reg;
    logic [CNT_W-1:0] m_gapt_reg;

    // Combinational helpers.
    logic [AW-1:0]    base;
    logic [ID_W-1:0]  cur;
    logic [HW-1:0]    held_cur;
    logic [CFG_W-1:0] win_eff;
    logic             free_found;
    logic [LW-1:0]    free_idx;
    logic             cmp_valid;
    logic [ID_W-1:0]  rd_id;
    logic [PAY_W-1:0] rd_pay;
    logic             scan_done;
    logic             low_gap;
    logic             out_last;
    kind_t            push_kind;
    logic [ID_W-1:0]  push_id;
    logic [PAY_W-1:0] push_pay;
    logic             push_gap;

    assign base      = AW'(AW'(s_reg) * AW'(SLOTS));
    assign cur       = cursor_reg[s_reg];
    assign held_cur  = held_reg[s_reg];
    assign win_eff   = (32'(win_reg) > 32'(WINDOW_MAX)) ? CFG_W'(WINDOW_MAX) : win_reg;
    assign cmp_valid = valid_reg[base + AW'(cidx_reg)];
    assign rd_id     = slot_rd_reg[SLW-1:PAY_W];
    assign rd_pay    = slot_rd_reg[PAY_W-1:0];
    assign scan_done = busy_reg && (cnt_reg == HW'(SLOTS)) && !pend_reg;
    assign low_gap   = low_id_reg > cur;
    assign out_last  = (rb_rd_idx_reg + HW'(1)) == rb_cnt_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[base + AW'(i)]) begin
                free_found = 1'b1;
                free_idx   = LW'(i);
            end
        end
    end

    always_comb begin
        case (cmd.push_sel)
            PSEL_ITEM: begin
                push_kind = KIND_DELIVER;
                push_id   = id_reg;
                push_pay  = pay_reg;
                push_gap  = 1'b0;
            end
            PSEL_HELD: begin
                push_kind = KIND_HELD;
                push_id   = id_reg;
                push_pay  = '0;
                push_gap  = 1'b0;
            end
            PSEL_DUP: begin
                push_kind = KIND_DUP;
                push_id   = id_reg;
                push_pay  = '0;
                push_gap  = 1'b0;
            end
            PSEL_MATCH: begin
                push_kind = KIND_DELIVER;
                push_id   = tgt_reg;
                push_pay  = match_pay_reg;
                push_gap  = gap_flag_reg;
            end
            PSEL_LOW: begin
                push_kind = KIND_DELIVER;
                push_id   = low_id_reg;
                push_pay  = low_pay_reg;
                push_gap  = low_gap;
            end
            default: begin
                push_kind = KIND_NONE;
                push_id   = '0;
                push_pay  = '0;
                push_gap  = 1'b0;
            end
        endcase
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= WINDOW_RESET;
        end else if (cfg_valid) begin
            win_reg <= cfg_data;
        end
    end

    // Item capture.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            act_reg <= s_action;
            s_reg   <= map_stream(s_stream_id);
            id_reg  <= s_msg_id;
            pay_reg <= s_payload;
        end
    end

    // Stream state and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg  <= '0;
            valid_reg    <= '0;
            dup_reg      <= '0;
            gap_reg      <= '0;
            gap_flag_reg <= 1'b0;
            for (int i = 0; i < STREAMS; i++) begin
                cursor_reg[i] <= '0;
                held_reg[i]   <= '0;
            end
        end else begin
            if (cmd.accept) begin
                gap_flag_reg <= 1'b0;
            end
            if (cmd.start_stream && !started_reg[s_reg]) begin
                started_reg[s_reg] <= 1'b1;
                cursor_reg[s_reg]  <= id_reg;
            end
            if (cmd.dup_inc) begin
                dup_reg <= dup_reg + 1'b1;
            end
            if (cmd.cur_inc) begin
                cursor_reg[s_reg] <= cur + 1'b1;
            end
            if (cmd.insert) begin
                valid_reg[base + AW'(free_idx)] <= 1'b1;
                held_reg[s_reg]                 <= held_cur + 1'b1;
            end
            if (cmd.win_jump) begin
                if (low_gap) begin
                    gap_reg <= gap_reg + 1'b1;
                end
                gap_flag_reg      <= low_gap;
                cursor_reg[s_reg] <= low_id_reg;
            end
            if (cmd.release_match) begin
                valid_reg[base + AW'(match_idx_reg)] <= 1'b0;
                held_reg[s_reg]                      <= held_cur - 1'b1;
                cursor_reg[s_reg]                    <= cur + 1'b1;
                gap_flag_reg                         <= 1'b0;
            end
            if (cmd.release_low) begin
                if (low_gap) begin
                    gap_reg <= gap_reg + 1'b1;
                end
                valid_reg[base + AW'(low_idx_reg)] <= 1'b0;
                held_reg[s_reg]                    <= held_cur - 1'b1;
                cursor_reg[s_reg]                  <= low_id_reg + 1'b1;
            end
        end
    end

    // Slot memory: one write port, one registered read port for the scan.
    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            slot_mem[base + AW'(free_idx)] <= {id_reg, pay_reg};
        end
        if (busy_reg && (cnt_reg < HW'(SLOTS))) begin
            slot_rd_reg <= slot_mem[base + AW'(cnt_reg[LW-1:0])];
        end
    end

    // Scan unit: one slot per cycle, finds the target id and the lowest id.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            cnt_reg   <= '0;
            match_reg <= 1'b0;
            low_reg   <= 1'b0;
        end else if (cmd.scan_start) begin
            busy_reg  <= 1'b1;
            pend_reg  <= 1'b0;
            cnt_reg   <= '0;
            match_reg <= 1'b0;
            low_reg   <= 1'b0;
            tgt_reg   <= cmd.scan_on_cursor ? cur : id_reg;
        end else if (busy_reg) begin
            if (scan_done) begin
                busy_reg <= 1'b0;
            end else begin
                pend_reg <= cnt_reg < HW'(SLOTS);
                cidx_reg <= cnt_reg[LW-1:0];
                if (cnt_reg < HW'(SLOTS)) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (pend_reg && cmp_valid) begin
                if (!match_reg && (rd_id == tgt_reg)) begin
                    match_reg     <= 1'b1;
                    match_idx_reg <= cidx_reg;
                    match_pay_reg <= rd_pay;
                end
                if (!low_reg || (rd_id < low_id_reg)) begin
                    low_reg     <= 1'b1;
                    low_idx_reg <= cidx_reg;
                    low_id_reg  <= rd_id;
                    low_pay_reg <= rd_pay;
                end
            end
        end
    end

    // Result buffer memory.
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            rb_mem[rb_cnt_reg[LW-1:0]] <= {push_kind, push_id, push_pay, push_gap};
        end
        if (cmd.out_read) begin
            rb_rd_reg <= rb_mem[rb_rd_idx_reg[LW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rb_cnt_reg    <= '0;
            rb_rd_idx_reg <= '0;
        end else begin
            if (cmd.accept) begin
                rb_cnt_reg    <= '0;
                rb_rd_idx_reg <= '0;
            end
            if (cmd.push) begin
                rb_cnt_reg <= rb_cnt_reg + 1'b1;
            end
            if (cmd.out_load) begin
                rb_rd_idx_reg <= rb_rd_idx_reg + 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_kind_reg   <= rb_rd_reg[RBW-1:RBW-2];
            m_id_reg     <= rb_rd_reg[RBW-3:PAY_W+1];
            m_pay_reg    <= rb_rd_reg[PAY_W:1];
            m_gap_reg    <= rb_rd_reg[0];
            m_stream_reg <= 2'(s_reg);
            m_last_reg   <= out_last;
            m_dup_reg    <= dup_reg;
            m_gapt_reg   <= gap_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_kind            = m_kind_reg;
    assign m_out_stream      = m_stream_reg;
    assign m_out_id          = m_id_reg;
    assign m_out_payload     = m_pay_reg;
    assign m_gap_before      = m_gap_reg;
    assign m_last            = m_last_reg;
    assign m_duplicate_total = m_dup_reg;
    assign m_gap_total       = m_gapt_reg;

    assign stat.is_flush    = act_reg == ACT_FLUSH;
    assign stat.id_lt_cur   = id_reg < cur;
    assign stat.id_eq_cur   = id_reg == cur;
    assign stat.scan_done   = scan_done;
    assign stat.match_found = match_reg;
    assign stat.low_found   = low_reg;
    assign stat.over_window = 32'(held_cur) > 32'(win_eff);
    assign stat.rb_empty    = rb_cnt_reg == '0;
    assign stat.out_free    = !m_valid_reg || m_ready;
    assign stat.out_last    = out_last;

    `WRD_ASSERT_IMP(a_insert_free, cmd.insert, free_found, "insert with no free slot")
    `WRD_ASSERT_IMP(a_scan_idle, cmd.scan_start, !busy_reg, "scan started while busy")
    `WRD_ASSERT_IMP(a_out_range, cmd.out_load, rb_rd_idx_reg < rb_cnt_reg, "readout past buffer")
    `WRD_ASSERT_IMP(a_release_held, cmd.release_match || cmd.release_low, held_cur != '0,
                    "release from an empty stream")
    `WRD_ASSERT(a_rb_bound, rb_cnt_reg <= HW'(SLOTS), "result buffer overflow")

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Windowed reorder delivery testbench
// Drives offers and flushes into the reorder block and checks every result
// against a cycle-free model of the per-stream cursors and held slots. The run
// starts with a table of hand-picked items, then walks through several window
// settings with random traffic and random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

    import wrd_pkg::*;

    localparam int NSTREAM   = 4;
    localparam int WMAX      = 16;
    localparam int NSLOT     = WMAX + 1;
    localparam int MAX_OUT   = 17;
    localparam int LIMIT     = 2000000;
    localparam int SETTLE    = 60;
    localparam int HOLD_OFF  = 400;
    localparam int PHASE_LEN = 40;

    typedef struct {
        kind_t       kind;
        logic [1:0]  st;
        logic [31:0] id;
        logic [63:0] pay;
        logic        gap;
        logic        last;
        logic [31:0] dups;
        logic [31:0] gaps;
    } delivery_t;

    // One row of the directed table. When typed is set, the kind of the first
    // result of the row is taken from the row itself instead of the model.
    typedef struct {
        logic        act;
        logic [1:0]  st;
        logic [31:0] id;
        logic [63:0] pay;
        logic        typed;
        kind_t       kind;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_action;
    logic [1:0]  s_stream_id;
    logic [31:0] s_msg_id;
    logic [63:0] s_payload;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_kind;
    logic [1:0]  m_out_stream;
    logic [31:0] m_out_id;
    logic [63:0] m_out_payload;
    logic        m_gap_before;
    logic        m_last;
    logic [31:0] m_duplicate_total;
    logic [31:0] m_gap_total;

    // Side information that travels with a directed row through the transfer.
    logic        row_typed;
    kind_t       row_kind;

    logic        pressure_go;
    int          mismatches;
    int          cycles;

    // Model state: window register, per-stream cursors and held slots.
    logic [4:0]  window_reg;
    bit          started     [NSTREAM];
    logic [31:0] cursor_of   [NSTREAM];
    bit          held_valid  [NSTREAM][NSLOT];
    logic [31:0] held_id     [NSTREAM][NSLOT];
    logic [63:0] held_pay    [NSTREAM][NSLOT];
    logic [31:0] dup_count;
    logic [31:0] gap_count;

    delivery_t   step_out[$];
    delivery_t   awaited_results[$];
    row_t        table_rows[$];

    windowed_reorder_delivery_top i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_stream_id       (s_stream_id),
        .s_msg_id          (s_msg_id),
        .s_payload         (s_payload),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_out_stream      (m_out_stream),
        .m_out_id          (m_out_id),
        .m_out_payload     (m_out_payload),
        .m_gap_before      (m_gap_before),
        .m_last            (m_last),
        .m_duplicate_total (m_duplicate_total),
        .m_gap_total       (m_gap_total)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------------
    // Reorder model
    // ------------------------------------------------------------------------

    function automatic void emit_result(kind_t k, logic [1:0] s, logic [31:0] id,
                                        logic [63:0] pay, logic gap);
        delivery_t r;
        if (step_out.size() < MAX_OUT) begin
            r.kind = k;
            r.st   = s;
            r.id   = id;
            r.pay  = pay;
            r.gap  = gap;
            r.last = 1'b0;
            r.dups = '0;
            r.gaps = '0;
            step_out.insert(step_out.size(), r);
        end
    endfunction

    function automatic int slot_holding(int s, logic [31:0] id);
        for (int i = 0; i < NSLOT; i++)
            if (held_valid[s][i] && held_id[s][i] == id)
                return i;
        return -1;
    endfunction

    function automatic int lowest_slot(int s);
        int best;
        best = -1;
        for (int i = 0; i < NSLOT; i++)
            if (held_valid[s][i] && (best < 0 || held_id[s][i] < held_id[s][best]))
                best = i;
        return best;
    endfunction

    function automatic int held_total(int s);
        int n;
        n = 0;
        for (int i = 0; i < NSLOT; i++)
            if (held_valid[s][i])
                n++;
        return n;
    endfunction

    // Releases the contiguous run of held ids starting at the cursor. Only the
    // first release of the run may carry the gap flag.
    function automatic void release_run(int s, logic gap);
        int k;
        logic g;
        g = gap;
        forever begin
            k = slot_holding(s, cursor_of[s]);
            if (k < 0)
                return;
            emit_result(KIND_DELIVER, s[1:0], cursor_of[s], held_pay[s][k], g);
            g = 1'b0;
            held_valid[s][k] = 1'b0;
            cursor_of[s] = cursor_of[s] + 32'd1;
        end
    endfunction

    function automatic void offer_message(int s, logic [31:0] id, logic [63:0] pay);
        int          win;
        int          k;
        logic [31:0] low;
        logic        gap;
        win = (window_reg > WMAX) ? WMAX : int'(window_reg);
        if (!started[s]) begin
            started[s]   = 1'b1;
            cursor_of[s] = id;
        end
        if (id < cursor_of[s] || (id > cursor_of[s] && slot_holding(s, id) >= 0)) begin
            dup_count = dup_count + 32'd1;
            emit_result(KIND_DUP, s[1:0], id, '0, 1'b0);
            return;
        end
        if (id == cursor_of[s]) begin
            emit_result(KIND_DELIVER, s[1:0], id, pay, 1'b0);
            cursor_of[s] = cursor_of[s] + 32'd1;
            release_run(s, 1'b0);
            return;
        end
        for (int i = 0; i < NSLOT; i++) begin
            if (!held_valid[s][i]) begin
                held_valid[s][i] = 1'b1;
                held_id[s][i]    = id;
                held_pay[s][i]   = pay;
                break;
            end
        end
        // Too many held: skip the cursor ahead to the lowest held id.
        while (held_total(s) > win) begin
            k = lowest_slot(s);
            if (k < 0)
                break;
            low = held_id[s][k];
            gap = 1'b0;
            if (low > cursor_of[s]) begin
                gap_count = gap_count + 32'd1;
                gap = 1'b1;
            end
            cursor_of[s] = low;
            release_run(s, gap);
        end
        if (step_out.size() == 0)
            emit_result(KIND_HELD, s[1:0], id, '0, 1'b0);
    endfunction

    function automatic void drain_all_held(int s);
        int          k;
        logic [31:0] low;
        logic        gap;
        forever begin
            k = lowest_slot(s);
            if (k < 0)
                break;
            low = held_id[s][k];
            gap = 1'b0;
            if (low > cursor_of[s]) begin
                gap_count = gap_count + 32'd1;
                gap = 1'b1;
            end
            cursor_of[s] = low + 32'd1;
            emit_result(KIND_DELIVER, s[1:0], low, held_pay[s][k], gap);
            held_valid[s][k] = 1'b0;
        end
        if (step_out.size() == 0)
            emit_result(KIND_NONE, s[1:0], '0, '0, 1'b0);
    endfunction

    function automatic void reorder_predict(logic act, logic [1:0] st, logic [31:0] id,
                                            logic [63:0] pay);
        delivery_t r;
        int        s;
        s = int'(st) % NSTREAM;
        step_out.delete();
        if (act == ACT_FLUSH)
            drain_all_held(s);
        else
            offer_message(s, id, pay);
        for (int k = 0; k < step_out.size(); k++) begin
            r      = step_out[k];
            r.last = (k == step_out.size() - 1);
            r.dups = dup_count;
            r.gaps = gap_count;
            awaited_results.insert(awaited_results.size(), r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking. Results are compared first, then a newly accepted item adds
    // its expectations, so both can happen on the same edge.
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin
        delivery_t e;
        logic      bad;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result: kind %0d stream %0d id %h",
                                 m_kind, m_out_stream, m_out_id);
                end else begin
                    e = awaited_results.pop_front();
                    bad = (m_kind !== e.kind) || (m_out_stream !== e.st) ||
                          (m_out_id !== e.id) || (m_out_payload !== e.pay) ||
                          (m_gap_before !== e.gap) || (m_last !== e.last) ||
                          (m_duplicate_total !== e.dups) || (m_gap_total !== e.gaps);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Mismatch expected: kind %0d st %0d id %h pay %h",
                                     e.kind, e.st, e.id, e.pay);
                            $display("  gap %b last %b dup %0d gaps %0d",
                                     e.gap, e.last, e.dups, e.gaps);
                            $display("         actual:   kind %0d st %0d id %h pay %h",
                                     m_kind, m_out_stream, m_out_id, m_out_payload);
                            $display("  gap %b last %b dup %0d gaps %0d",
                                     m_gap_before, m_last, m_duplicate_total, m_gap_total);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                window_reg = cfg_data;
            if (s_valid && s_ready) begin
                reorder_predict(s_action, s_stream_id, s_msg_id, s_payload);
                // A typed row states the first result's kind directly.
                if (row_typed)
                    awaited_results[awaited_results.size() - step_out.size()].kind = row_kind;
            end
        end
    end

    // The run is cut off if it hangs.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: one long hold-off to back the block up, then a stall pattern
    // that picks a new duty for each stretch, including stretches with no stall.
    // ------------------------------------------------------------------------

    initial begin
        int mode;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        while (!pressure_go) begin
            m_ready <= ($urandom_range(0, 3) != 0);
            @(posedge aclk);
        end
        m_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge aclk);
        forever begin
            mode = $urandom_range(0, 3);
            for (int c = 0; c < 64; c++) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (c % 8) < 5;
                endcase
                @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Presents one item and returns at the edge where its transfer happens.
    task automatic send_item(logic act, logic [1:0] st, logic [31:0] id,
                             logic [63:0] pay, logic typed, kind_t k);
        s_valid     <= 1'b1;
        s_action    <= act;
        s_stream_id <= st;
        s_msg_id    <= id;
        s_payload   <= pay;
        row_typed   <= typed;
        row_kind    <= k;
        do
            @(posedge aclk);
        while (!(s_valid && s_ready));
    endtask

    // Drops valid for a random gap; a zero gap keeps the burst going.
    task automatic sender_gap(int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Waits until the block has nothing outstanding, then writes the window.
    task automatic write_window(logic [4:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_row(logic act, logic [1:0] st, logic [31:0] id,
                                    logic [63:0] pay, logic typed, kind_t k);
        row_t r;
        r.act   = act;
        r.st    = st;
        r.id    = id;
        r.pay   = pay;
        r.typed = typed;
        r.kind  = k;
        table_rows.insert(table_rows.size(), r);
    endfunction

    // Picks a random item that mostly follows the stream's cursor, so that
    // runs get drained and windows overflow, with some duplicates and noise.
    task automatic send_random(logic [4:0] win);
        int          s;
        int          pick;
        logic [31:0] id;
        logic [63:0] pay;
        logic        act;
        s    = $urandom_range(0, NSTREAM - 1);
        pick = $urandom_range(0, 99);
        pay  = {$urandom, $urandom};
        act  = ACT_OFFER;
        if (pick < 7)
            act = ACT_FLUSH;
        if (pick < 14 || !started[s])
            id = $urandom;
        else if (pick < 24)
            id = cursor_of[s] - $urandom_range(1, 3);
        else if (pick < 40)
            id = cursor_of[s];
        else
            id = cursor_of[s] + $urandom_range(1, (win > WMAX ? WMAX : win) + 3);
        send_item(act, s[1:0], id, pay, 1'b0, KIND_DELIVER);
    endtask

    initial begin
        logic [4:0] windows[6];
        int         burst;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_action    = ACT_OFFER;
        s_stream_id = '0;
        s_msg_id    = '0;
        s_payload   = '0;
        row_typed   = 1'b0;
        row_kind    = KIND_DELIVER;
        pressure_go = 1'b0;
        mismatches  = 0;
        cycles      = 0;
        window_reg  = WINDOW_RESET;
        dup_count   = '0;
        gap_count   = '0;
        for (int s = 0; s < NSTREAM; s++) begin
            started[s]   = 1'b0;
            cursor_of[s] = '0;
            for (int i = 0; i < NSLOT; i++)
                held_valid[s][i] = 1'b0;
        end
        windows = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd5, 5'd0};
        windows[5] = 5'($urandom_range(0, 31));

        // Stream 0: first offer sets the cursor, then a duplicate below it, a
        // held id, a repeat of that held id, and the id that releases the run.
        add_row(ACT_OFFER, 2'd0, 32'd100, 64'h0, 1'b1, KIND_DELIVER);
        add_row(ACT_OFFER, 2'd0, 32'd99, 64'h1, 1'b1, KIND_DUP);
        add_row(ACT_OFFER, 2'd0, 32'd102, 64'hffff_ffff_ffff_ffff, 1'b1, KIND_HELD);
        add_row(ACT_OFFER, 2'd0, 32'd102, 64'h2, 1'b1, KIND_DUP);
        add_row(ACT_OFFER, 2'd0, 32'd101, 64'h3, 1'b0, KIND_DELIVER);
        add_row(ACT_FLUSH, 2'd0, 32'd0, 64'h0, 1'b1, KIND_NONE);
        // A flush of a stream that was never offered releases nothing.
        add_row(ACT_FLUSH, 2'd3, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1, KIND_NONE);
        // Stream 1: the cursor wraps from the top id to zero, and the top id
        // minus one then counts as far ahead of the cursor, not behind it.
        add_row(ACT_OFFER, 2'd1, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1, KIND_DELIVER);
        add_row(ACT_OFFER, 2'd1, 32'h0, 64'h0, 1'b1, KIND_DELIVER);
        add_row(ACT_OFFER, 2'd1, 32'hffff_fffe, 64'h5a5a_a5a5_0f0f_f0f0, 1'b1, KIND_HELD);
        add_row(ACT_OFFER, 2'd1, 32'd5, 64'h5, 1'b1, KIND_HELD);
        add_row(ACT_OFFER, 2'd1, 32'd3, 64'h3, 1'b1, KIND_HELD);
        add_row(ACT_FLUSH, 2'd1, 32'd0, 64'h0, 1'b0, KIND_DELIVER);
        // Stream 2: overflow the reset window of eight so the cursor skips.
        add_row(ACT_OFFER, 2'd2, 32'd10, 64'ha, 1'b1, KIND_DELIVER);
        for (int i = 12; i <= 20; i++)
            add_row(ACT_OFFER, 2'd2, i, {32'hc0de_0000, 32'(i)}, 1'b0, KIND_DELIVER);
        add_row(ACT_OFFER, 2'd2, 32'd1, 64'h0, 1'b1, KIND_DUP);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (table_rows[i]) begin
            send_item(table_rows[i].act, table_rows[i].st, table_rows[i].id,
                      table_rows[i].pay, table_rows[i].typed, table_rows[i].kind);
            sender_gap($urandom_range(0, 3));
        end

        // Random phases, one per window setting. The long receiver hold-off
        // starts with the first phase while the sender keeps offering.
        foreach (windows[p]) begin
            write_window(windows[p]);
            if (p == 0)
                pressure_go = 1'b1;
            for (int n = 0; n < PHASE_LEN; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < PHASE_LEN; b++, n++)
                    send_random(windows[p]);
                sender_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            end
        end
        s_valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
